### hdl/sbcg_pkg.sv
// Shared types, phase codes and the blink pattern table for the status blink code generator.
package sbcg_pkg;

    localparam int StatusW = 3;
    localparam int RepeatW = 8;
    localparam int TickW   = 11;
    localparam int PulseW  = 3;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_ON    = 2'd1,
        PH_OFF   = 2'd2,
        PH_PAUSE = 2'd3
    } phase_t;

    typedef enum logic {
        ACT_TICK  = 1'b0,
        ACT_START = 1'b1
    } action_t;

    typedef struct packed {
        logic [PulseW-1:0] pulses;
        logic [TickW-1:0]  on_ms;
        logic [TickW-1:0]  off_ms;
        logic [TickW-1:0]  pause_ms;
    } pattern_t;

    typedef struct packed {
        logic               action;
        logic [StatusW-1:0] status_code;
        logic [RepeatW-1:0] repeat_count;
    } req_item_t;

    typedef struct packed {
        logic led_drive;
        logic busy_res;
    } rsp_item_t;

    // Off codes come back with zero pulses.
    function automatic pattern_t pattern_lookup(input logic [StatusW-1:0] code);
        pattern_t p;
        case (code)
            3'd0:    p = '{3'd1, 11'd100, 11'd100, 11'd500};
            3'd1:    p = '{3'd2, 11'd100, 11'd100, 11'd500};
            3'd2:    p = '{3'd3, 11'd100, 11'd100, 11'd500};
            3'd4:    p = '{3'd2, 11'd200, 11'd200, 11'd1500};
            3'd5:    p = '{3'd3, 11'd200, 11'd200, 11'd1500};
            3'd6:    p = '{3'd4, 11'd200, 11'd200, 11'd1500};
            default: p = '{3'd0, 11'd0, 11'd0, 11'd0};
        endcase
        return p;
    endfunction

endpackage

### hdl/sbcg_if.sv
// Valid/ready channel interfaces for request and response items.
interface sbcg_req_if
    import sbcg_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               action;
    logic [StatusW-1:0] status_code;
    logic [RepeatW-1:0] repeat_count;

    modport source (output valid, output action, output status_code, output repeat_count,
                    input ready);
    modport sink   (input valid, input action, input status_code, input repeat_count,
                    output ready);
endinterface

interface sbcg_rsp_if;
    logic valid;
    logic ready;
    logic led_drive;
    logic busy_res;

    modport source (output valid, output led_drive, output busy_res, input ready);
    modport sink   (input valid, input led_drive, input busy_res, output ready);
endinterface

### hdl/sbcg_in_stage.sv
// Input register that captures one request item per cycle while it is empty or its item advances.
module sbcg_in_stage
    import sbcg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    sbcg_req_if.sink  req,
    input  logic      advance,
    output logic      item_valid,
    output req_item_t item
);

    logic      valid_reg;
    logic      valid_next;
    req_item_t item_reg;

    assign req.ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (req.ready)
        begin
            valid_next = req.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            item_reg <= '{req.action, req.status_code, req.repeat_count};
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### hdl/sbcg_core.sv
// Blink sequencer state, polarity register and per-item next-state logic.
module sbcg_core
    import sbcg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  logic      wr_data,
    input  logic      step,
    input  req_item_t item,
    output rsp_item_t result
);

    phase_t             phase_reg, phase_next;
    logic [TickW-1:0]   tick_count_reg, tick_count_next;
    logic [PulseW-1:0]  pulses_done_reg, pulses_done_next;
    logic [RepeatW-1:0] repeats_left_reg, repeats_left_next;
    logic [StatusW-1:0] current_status_reg, current_status_next;
    logic               led_lit_reg, led_lit_next;
    logic               active_low_reg;

    pattern_t           pat;
    pattern_t           start_pat;
    logic [TickW-1:0]   tick_inc;
    logic [PulseW-1:0]  pulses_inc;

    assign pat        = pattern_lookup(current_status_reg);
    assign start_pat  = pattern_lookup(item.status_code);
    assign tick_inc   = tick_count_reg + 1'b1;
    assign pulses_inc = pulses_done_reg + 1'b1;

    // Next state
    always_comb
    begin
        phase_next          = phase_reg;
        tick_count_next     = tick_count_reg;
        pulses_done_next    = pulses_done_reg;
        repeats_left_next   = repeats_left_reg;
        current_status_next = current_status_reg;
        led_lit_next        = led_lit_reg;
        if (step)
        begin
            if (item.action == ACT_START)
            begin
                current_status_next = item.status_code;
                tick_count_next     = '0;
                pulses_done_next    = '0;
                if (start_pat.pulses == '0 || item.repeat_count == '0)
                begin
                    phase_next        = PH_IDLE;
                    repeats_left_next = '0;
                    led_lit_next      = 1'b0;
                end
                else
                begin
                    phase_next        = PH_ON;
                    repeats_left_next = item.repeat_count;
                    led_lit_next      = 1'b1;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_ON:
                    begin
                        tick_count_next = tick_inc;
                        if (tick_inc >= pat.on_ms)
                        begin
                            led_lit_next    = 1'b0;
                            phase_next      = PH_OFF;
                            tick_count_next = '0;
                        end
                    end
                    PH_OFF:
                    begin
                        tick_count_next = tick_inc;
                        if (tick_inc >= pat.off_ms)
                        begin
                            tick_count_next  = '0;
                            pulses_done_next = pulses_inc;
                            if (pulses_inc >= pat.pulses)
                            begin
                                phase_next = PH_PAUSE;
                            end
                            else
                            begin
                                phase_next   = PH_ON;
                                led_lit_next = 1'b1;
                            end
                        end
                    end
                    PH_PAUSE:
                    begin
                        tick_count_next = tick_inc;
                        if (tick_inc >= pat.pause_ms)
                        begin
                            tick_count_next   = '0;
                            pulses_done_next  = '0;
                            repeats_left_next = repeats_left_reg - 1'b1;
                            if (repeats_left_reg == 8'd1)
                            begin
                                phase_next   = PH_IDLE;
                                led_lit_next = 1'b0;
                            end
                            else
                            begin
                                phase_next   = PH_ON;
                                led_lit_next = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    // Outputs
    always_comb
    begin
        result.led_drive = led_lit_next ^ active_low_reg;
        result.busy_res  = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            tick_count_reg     <= '0;
            pulses_done_reg    <= '0;
            repeats_left_reg   <= '0;
            current_status_reg <= '0;
            led_lit_reg        <= 1'b0;
            active_low_reg     <= 1'b1;
        end
        else
        begin
            phase_reg          <= phase_next;
            tick_count_reg     <= tick_count_next;
            pulses_done_reg    <= pulses_done_next;
            repeats_left_reg   <= repeats_left_next;
            current_status_reg <= current_status_next;
            led_lit_reg        <= led_lit_next;
            if (wr_en)
            begin
                active_low_reg <= wr_data;
            end
        end
    end

`ifndef SYNTHESIS
    a_lit_only_on: assert property (@(posedge clk) disable iff (!rst_n)
        led_lit_reg == (phase_reg == PH_ON))
        else $error("led lit state disagrees with phase");

    a_busy_has_repeats: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> (repeats_left_reg != '0))
        else $error("running sequence with no repeats left");

    a_on_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ON) |-> (tick_count_reg < pat.on_ms))
        else $error("on phase ran past its on time");

    a_pulses_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ON || phase_reg == PH_OFF) |-> (pulses_done_reg < pat.pulses))
        else $error("burst ran past its pulse count");

    a_idle_tick_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (step && item.action == ACT_TICK && phase_reg == PH_IDLE)
        |=> (phase_reg == PH_IDLE && $stable(tick_count_reg)))
        else $error("tick changed state while idle");
`endif

endmodule

### hdl/sbcg_out_stage.sv
// Result register that holds one response item until the sink takes it.
module sbcg_out_stage
    import sbcg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  rsp_item_t result,
    output logic      can_load,
    sbcg_rsp_if.source rsp
);

    logic      valid_reg;
    logic      valid_next;
    rsp_item_t result_reg;

    assign can_load = !valid_reg || rsp.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (can_load)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_load && load)
        begin
            result_reg <= result;
        end
    end

    assign rsp.valid     = valid_reg;
    assign rsp.led_drive = result_reg.led_drive;
    assign rsp.busy_res  = result_reg.busy_res;

endmodule

### hdl/status_blink_code_generator_unit.sv
// Top level of the status LED blink code generator.
// Takes one item per clock while results are taken: a start item loads a status pattern and
// repeat count, a tick item advances the running sequence by one millisecond, and each item
// returns one result with the LED pin level and a busy flag. An accepted item passes through the
// input register, then the result register; the sequencer state updates as it moves from the
// input register into the result register, so throughput is one item per cycle whenever the
// sink keeps taking results. Write active_low only while no item is in flight.
module status_blink_code_generator_unit
    import sbcg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  logic       wr_data,
    sbcg_req_if.sink   req,
    sbcg_rsp_if.source rsp
);

    logic      item_valid;
    req_item_t item;
    logic      can_load;
    logic      step;
    rsp_item_t result;

    // Move an item into the result register only when that register frees up.
    assign step = item_valid && can_load;

    sbcg_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .advance    (can_load),
        .item_valid (item_valid),
        .item       (item)
    );

    sbcg_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_data (wr_data),
        .step    (step),
        .item    (item),
        .result  (result)
    );

    sbcg_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (item_valid),
        .result   (result),
        .can_load (can_load),
        .rsp      (rsp)
    );

endmodule
